/* src/phrd_pkg.sv */
// Package for the peak-hold rate decimator: widths, constants, state codes
// and the command and status bundles between controller and datapath.
// No dependencies.
package phrd_pkg;

  localparam int SampleW = 24;
  localparam int RateW   = 20;
  localparam int PosW    = 21;
  localparam int OpW     = PosW + 1;
  localparam int ProdW   = OpW + RateW;
  localparam int CntW    = 6;
  localparam int StepW   = 5;

  localparam logic [RateW-1:0]   RateReset = RateW'(48000);
  localparam logic [CntW-1:0]    MaxPre    = CntW'(33);
  localparam logic [StepW-1:0]   LastStep  = StepW'(PosW - 1);
  localparam logic [SampleW-1:0] PeakMax   = SampleW'(8388608);

  localparam logic CfgInRate  = 1'b0;
  localparam logic CfgOutRate = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_EMIT,
    ST_RBCHK,
    ST_DIV,
    ST_KMUL,
    ST_SUB,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic mul_k;
    logic absorb;
    logic emit;
    logic flush;
    logic sub_one;
    logic div_start;
    logic sub;
  } cmd_t;

  typedef struct packed {
    logic reached;
    logic obuf_free;
    logic pend_valid;
    logic rb_ge;
    logic rb_one;
    logic div_done;
  } status_t;

endpackage

/* src/phrd_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on phrd_pkg.
module phrd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [phrd_pkg::PosW-1:0]  dividend,
  input  logic [phrd_pkg::RateW-1:0] divisor,
  output logic [phrd_pkg::PosW-1:0]  quotient,
  output logic                      done
);
  import phrd_pkg::*;

  logic             busy;
  logic [StepW-1:0] step;
  logic [RateW-1:0] rem;
  logic [PosW-1:0]  shifted;
  logic             ge;

  assign shifted = {rem, quotient[PosW-1]};
  assign ge      = shifted >= PosW'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + StepW'(1);
      if (step == LastStep) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[PosW-2:0], ge};
      rem      <= ge ? RateW'(shifted - PosW'(divisor)) : RateW'(shifted);
    end
  end

endmodule

/* src/phrd_datapath.sv */
// Datapath: rate registers, position counters, held peak, boundary
// multipliers, rebase dividers, pending result and output register.
// Depends on phrd_pkg and phrd_div.
module phrd_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [phrd_pkg::RateW-1:0]   cfg_data,
  input  logic [phrd_pkg::SampleW-1:0] s_tdata,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [phrd_pkg::SampleW-1:0] m_tdata,
  output logic                        m_tlast,
  input  phrd_pkg::cmd_t               cmd,
  output phrd_pkg::status_t            st
);
  import phrd_pkg::*;

  logic [RateW-1:0]   in_rate;
  logic [RateW-1:0]   out_rate;
  logic [RateW-1:0]   ir;
  logic [RateW-1:0]   orr;
  logic [SampleW-1:0] sample;
  logic [SampleW-1:0] mag;
  logic [SampleW-1:0] held_peak;
  logic [SampleW-1:0] pend_peak;
  logic               pend_valid;
  logic [PosW-1:0]    in_pos;
  logic [PosW-1:0]    out_pos;
  logic [ProdW-1:0]   prod_a;
  logic [ProdW-1:0]   prod_b;
  logic [OpW-1:0]     op_a;
  logic [OpW-1:0]     op_b;
  logic [PosW-1:0]    q_in;
  logic [PosW-1:0]    q_out;
  logic [PosW-1:0]    k;
  logic               done_in;
  logic               done_out;
  logic               obuf_free;

  assign ir  = (in_rate == '0) ? RateW'(1) : in_rate;
  assign orr = (out_rate == '0) ? RateW'(1) : out_rate;
  assign mag = sample[SampleW-1] ? SampleW'(~sample + SampleW'(1)) : sample;
  assign k   = (q_in < q_out) ? q_in : q_out;

  assign op_a = cmd.mul_k ? OpW'(k) : OpW'(out_pos) + OpW'(1);
  assign op_b = cmd.mul_k ? OpW'(k) : OpW'(in_pos) + OpW'(1);

  assign obuf_free = !m_tvalid || m_tready;

  assign st.reached    = prod_a < prod_b;
  assign st.obuf_free  = obuf_free;
  assign st.pend_valid = pend_valid;
  assign st.rb_ge      = (in_pos >= PosW'(ir)) && (out_pos >= PosW'(orr));
  assign st.rb_one     = (in_pos < {ir, 1'b0}) || (out_pos < {orr, 1'b0});
  assign st.div_done   = done_in && done_out;

  phrd_div u_div_in (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (in_pos),
    .divisor  (ir),
    .quotient (q_in),
    .done     (done_in)
  );

  phrd_div u_div_out (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (out_pos),
    .divisor  (orr),
    .quotient (q_out),
    .done     (done_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rate  <= RateReset;
      out_rate <= RateReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgInRate:  in_rate  <= cfg_data;
        CfgOutRate: out_rate <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= s_tdata;
    end
    if (cmd.mul) begin
      prod_a <= ProdW'(op_a) * ProdW'(ir);
      prod_b <= ProdW'(op_b) * ProdW'(orr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_peak <= '0;
      in_pos    <= '0;
      out_pos   <= '0;
    end else begin
      if (cmd.absorb) begin
        if (mag > held_peak) begin
          held_peak <= mag;
        end
        in_pos <= in_pos + PosW'(1);
      end
      if (cmd.emit) begin
        held_peak <= '0;
        out_pos   <= out_pos + PosW'(1);
      end
      if (cmd.sub_one) begin
        in_pos  <= in_pos - PosW'(ir);
        out_pos <= out_pos - PosW'(orr);
      end
      if (cmd.sub) begin
        in_pos  <= in_pos - prod_a[PosW-1:0];
        out_pos <= out_pos - prod_b[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.emit && pend_valid) || cmd.flush) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_peak <= held_peak;
    end
    if ((cmd.emit && pend_valid) || cmd.flush) begin
      m_tdata <= pend_peak;
      m_tlast <= cmd.flush;
    end
  end

endmodule

/* src/phrd_ctrl.sv */
// Controller: sequences boundary checks, emits, absorb, rebase and flush
// for one sample at a time. Depends on phrd_pkg.
module phrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output phrd_pkg::cmd_t     cmd,
  input  phrd_pkg::status_t  st
);
  import phrd_pkg::*;

  state_t          state;
  state_t          state_next;
  logic            post;
  logic            post_next;
  logic [CntW-1:0] n;
  logic [CntW-1:0] n_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      post  <= 1'b0;
      n     <= '0;
    end else begin
      state <= state_next;
      post  <= post_next;
      n     <= n_next;
    end
  end

  always_comb begin
    state_next = state;
    post_next  = post;
    n_next     = n;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          post_next  = 1'b0;
          n_next     = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!post) begin
          if (st.reached && (n < MaxPre)) begin
            state_next = ST_EMIT;
          end else begin
            cmd.absorb = 1'b1;
            post_next  = 1'b1;
            state_next = ST_MUL;
          end
        end else begin
          state_next = st.reached ? ST_EMIT : ST_RBCHK;
        end
      end
      ST_EMIT: begin
        if (!st.pend_valid || st.obuf_free) begin
          cmd.emit   = 1'b1;
          n_next     = n + CntW'(1);
          state_next = post ? ST_RBCHK : ST_MUL;
        end
      end
      ST_RBCHK: begin
        if (!st.rb_ge) begin
          state_next = ST_FLUSH;
        end else if (st.rb_one) begin
          cmd.sub_one = 1'b1;
          state_next  = ST_FLUSH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (st.div_done) begin
          state_next = ST_KMUL;
        end
      end
      ST_KMUL: begin
        cmd.mul    = 1'b1;
        cmd.mul_k  = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!st.pend_valid) begin
          state_next = ST_IDLE;
        end else if (st.obuf_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/peak_hold_rate_decimator_unit.sv */
// Top level of the peak-hold rate decimator: controller plus datapath.
// Depends on phrd_pkg, phrd_ctrl and phrd_datapath.
//
//   channel  direction  payload
//   s_       in         tdata[23:0] sample (signed Q1.23)
//   m_       out        tdata[23:0] peak (unsigned Q1.23), tlast = last
//   cfg_     in         index 0 in_rate, 1 out_rate, data[19:0]
//
// Each sample runs from acceptance through the multiply and compare steps to
// the next ready, with an emit step for each window that it closes. A rebase
// by more than one period runs two 21-step shift-subtract dividers.
// Results wait in one pending register and one output register; a stalled
// m_tready holds the controller in its emit or flush step.
// rst is synchronous and returns rates to 48000 and all counters to zero.
module peak_hold_rate_decimator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [phrd_pkg::SampleW-1:0] s_tdata,   // [23:0] sample
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [phrd_pkg::SampleW-1:0] m_tdata,   // [23:0] peak
  output logic                        m_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [phrd_pkg::RateW-1:0]   cfg_data
);
  import phrd_pkg::*;

  cmd_t    cmd;
  status_t st;

  phrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .st       (st)
  );

  phrd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

/* src/phrd_checker.sv */
// Port-level checks for the peak-hold rate decimator, bound to the top level.
// Depends on phrd_pkg and peak_hold_rate_decimator_unit.
module phrd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [phrd_pkg::SampleW-1:0] m_tdata,
  input logic                        m_tlast
);
  import phrd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready again in the cycle after an input transaction");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= PeakMax)
    else $error("peak above full-scale magnitude");

endmodule

bind peak_hold_rate_decimator_unit phrd_checker u_phrd_checker (.*);
